@@ design/mcs_pkg.sv @@
// ----------------------------------------------------------------------------
// mcs_pkg
// Shared constants, register codes and types of the matrix cumulative sum.
// ----------------------------------------------------------------------------
package mcs_pkg;

    localparam int DEF_MAX_ROW_LENGTH = 1024;
    localparam int DEF_MAX_PLANES     = 4;

    localparam int SAMPLE_W   = 32;
    localparam int SUM_W      = 48;
    localparam int ROWS_W     = 16;
    localparam int LEN_W      = 11;
    localparam int PLANES_W   = 3;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SUM_DIRECTION = 2'd0,
        REG_ROW_LENGTH    = 2'd1,
        REG_ROW_COUNT     = 2'd2,
        REG_PLANE_COUNT   = 2'd3
    } cfg_reg_t;

    // Position marks that travel with an item from the counters to the adder
    typedef struct packed {
        logic row_first;
        logic cell_first;
        logic last_item;
    } pos_flags_t;

endpackage

@@ design/mcs_config.sv @@
// ----------------------------------------------------------------------------
// mcs_config
// Configuration registers, kept as clamped last-index limits.
// ----------------------------------------------------------------------------
module mcs_config #(
    parameter int MAX_ROW_LENGTH = mcs_pkg::DEF_MAX_ROW_LENGTH,
    parameter int MAX_PLANES     = mcs_pkg::DEF_MAX_PLANES,
    localparam int CW = $clog2(MAX_ROW_LENGTH),
    localparam int PW = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  mcs_pkg::cfg_reg_t                cfg_index,
    input  logic [mcs_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                             dir,
    output logic [CW-1:0]                    last_cell,
    output logic [PW-1:0]                    last_plane,
    output logic [mcs_pkg::ROWS_W-1:0]       last_row
);
    import mcs_pkg::*;

    logic                dir_reg;
    logic [CW-1:0]       last_cell_reg,  last_cell_next;
    logic [PW-1:0]       last_plane_reg, last_plane_next;
    logic [ROWS_W-1:0]   last_row_reg,   last_row_next;
    logic [LEN_W-1:0]    len_v;
    logic [PLANES_W-1:0] planes_v;
    logic [ROWS_W-1:0]   rows_v;

    assign len_v    = cfg_data[LEN_W-1:0];
    assign planes_v = cfg_data[PLANES_W-1:0];
    assign rows_v   = cfg_data[ROWS_W-1:0];

    // Zero acts as one; oversize clamps to the maximum
    always_comb
    begin
        if (len_v == '0)
            last_cell_next = '0;
        else if (32'(len_v) > 32'(MAX_ROW_LENGTH))
            last_cell_next = CW'(MAX_ROW_LENGTH - 1);
        else
            last_cell_next = CW'(len_v - LEN_W'(1));

        if (planes_v == '0)
            last_plane_next = '0;
        else if (32'(planes_v) > 32'(MAX_PLANES))
            last_plane_next = PW'(MAX_PLANES - 1);
        else
            last_plane_next = PW'(planes_v - PLANES_W'(1));

        if (rows_v == '0)
            last_row_next = '0;
        else
            last_row_next = rows_v - ROWS_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg        <= 1'b0;
            last_cell_reg  <= '0;
            last_plane_reg <= '0;
            last_row_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SUM_DIRECTION: dir_reg        <= cfg_data[0];
                REG_ROW_LENGTH:    last_cell_reg  <= last_cell_next;
                REG_ROW_COUNT:     last_row_reg   <= last_row_next;
                REG_PLANE_COUNT:   last_plane_reg <= last_plane_next;
                default:           dir_reg        <= dir_reg;
            endcase
        end
    end

    assign dir        = dir_reg;
    assign last_cell  = last_cell_reg;
    assign last_plane = last_plane_reg;
    assign last_row   = last_row_reg;

endmodule

@@ design/mcs_position.sv @@
// ----------------------------------------------------------------------------
// mcs_position
// Plane, cell and row counters; column store address of the incoming item.
// ----------------------------------------------------------------------------
module mcs_position #(
    parameter int MAX_ROW_LENGTH = mcs_pkg::DEF_MAX_ROW_LENGTH,
    parameter int MAX_PLANES     = mcs_pkg::DEF_MAX_PLANES,
    localparam int CW = $clog2(MAX_ROW_LENGTH),
    localparam int PW = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1,
    localparam int AW = $clog2(MAX_ROW_LENGTH * MAX_PLANES)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         restart,
    input  logic                         accept,
    input  logic [CW-1:0]                last_cell,
    input  logic [PW-1:0]                last_plane,
    input  logic [mcs_pkg::ROWS_W-1:0]   last_row,
    output logic [PW-1:0]                plane,
    output logic [AW-1:0]                addr,
    output mcs_pkg::pos_flags_t          flags
);
    import mcs_pkg::*;

    logic [PW-1:0]     plane_reg;
    logic [CW-1:0]     cell_reg;
    logic [ROWS_W-1:0] row_reg;
    logic              at_last_plane, at_last_cell, at_last_row;

    assign at_last_plane = (plane_reg == last_plane);
    assign at_last_cell  = (cell_reg == last_cell);
    assign at_last_row   = (row_reg == last_row);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_reg <= '0;
            cell_reg  <= '0;
            row_reg   <= '0;
        end
        else if (restart)
        begin
            plane_reg <= '0;
            cell_reg  <= '0;
            row_reg   <= '0;
        end
        else if (accept)
        begin
            if (!at_last_plane)
                plane_reg <= plane_reg + PW'(1);
            else
            begin
                plane_reg <= '0;
                if (!at_last_cell)
                    cell_reg <= cell_reg + CW'(1);
                else
                begin
                    cell_reg <= '0;
                    row_reg  <= at_last_row ? '0 : row_reg + ROWS_W'(1);
                end
            end
        end
    end

    assign plane            = plane_reg;
    assign addr             = AW'(cell_reg) * AW'(MAX_PLANES) + AW'(plane_reg);
    assign flags.row_first  = (row_reg == '0);
    assign flags.cell_first = (cell_reg == '0);
    assign flags.last_item  = at_last_plane && at_last_cell && at_last_row;

    // Counters never pass their limits, so the equality wraps are enough
    a_plane_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        plane_reg <= last_plane && cell_reg <= last_cell && row_reg <= last_row)
        else $error("position counter beyond configured limit");

endmodule

@@ design/mcs_column_store.sv @@
// ----------------------------------------------------------------------------
// mcs_column_store
// Line store of previous-row column sums, registered read with write bypass.
// ----------------------------------------------------------------------------
module mcs_column_store #(
    parameter int MAX_ROW_LENGTH = mcs_pkg::DEF_MAX_ROW_LENGTH,
    parameter int MAX_PLANES     = mcs_pkg::DEF_MAX_PLANES,
    localparam int DEPTH = MAX_ROW_LENGTH * MAX_PLANES,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               rd_en,
    input  logic [AW-1:0]                      rd_addr,
    output logic signed [mcs_pkg::SUM_W-1:0]   rd_data,
    input  logic                               wr_en,
    input  logic [AW-1:0]                      wr_addr,
    input  logic signed [mcs_pkg::SUM_W-1:0]   wr_data
);
    import mcs_pkg::*;

    logic signed [SUM_W-1:0] mem [DEPTH];
    logic signed [SUM_W-1:0] rd_mem_reg;
    logic signed [SUM_W-1:0] byp_data_reg;
    logic                    byp_sel_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
        begin
            rd_mem_reg   <= mem[rd_addr];
            byp_data_reg <= wr_data;
        end
    end

    // A write to the same entry in the read cycle lands too late for the array
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            byp_sel_reg <= 1'b0;
        else if (rd_en)
            byp_sel_reg <= wr_en && (wr_addr == rd_addr);
    end

    assign rd_data = byp_sel_reg ? byp_data_reg : rd_mem_reg;

endmodule

@@ design/mcs_accum.sv @@
// ----------------------------------------------------------------------------
// mcs_accum
// Add stage with saturation, row-mode plane sums and the output register.
// ----------------------------------------------------------------------------
module mcs_accum #(
    parameter int MAX_ROW_LENGTH = mcs_pkg::DEF_MAX_ROW_LENGTH,
    parameter int MAX_PLANES     = mcs_pkg::DEF_MAX_PLANES,
    localparam int PW = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1,
    localparam int AW = $clog2(MAX_ROW_LENGTH * MAX_PLANES)
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  dir,
    input  logic                                  accept,
    input  logic signed [mcs_pkg::SAMPLE_W-1:0]   sample,
    input  logic [PW-1:0]                         plane,
    input  logic [AW-1:0]                         addr,
    input  mcs_pkg::pos_flags_t                   flags,
    output logic                                  free,
    input  logic signed [mcs_pkg::SUM_W-1:0]      col_data,
    output logic                                  col_we,
    output logic [AW-1:0]                         col_addr,
    output logic signed [mcs_pkg::SUM_W-1:0]      col_wdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic signed [mcs_pkg::SUM_W-1:0]      m_tdata,
    output logic                                  m_tuser,
    output logic                                  m_tlast
);
    import mcs_pkg::*;

    logic                    s1_valid_reg;
    logic signed [SAMPLE_W-1:0] s1_sample_reg;
    logic [PW-1:0]           s1_plane_reg;
    logic [AW-1:0]           s1_addr_reg;
    pos_flags_t              s1_flags_reg;
    logic signed [SUM_W-1:0] plane_sums_reg [MAX_PLANES];

    logic                    out_valid_reg;
    logic signed [SUM_W-1:0] out_sum_reg;
    logic                    out_sat_reg;
    logic                    out_last_reg;

    logic                    s1_go;
    logic signed [SUM_W-1:0] base;
    logic signed [SUM_W:0]   wide;
    logic                    sat;
    logic signed [SUM_W-1:0] sum;

    assign s1_go = s1_valid_reg && (!out_valid_reg || m_tready);
    assign free  = !s1_valid_reg || s1_go;

    always_comb
    begin
        if (dir)
            base = s1_flags_reg.row_first ? '0 : col_data;
        else
            base = s1_flags_reg.cell_first ? '0 : plane_sums_reg[s1_plane_reg];
        wide = {base[SUM_W-1], base}
             + {{(SUM_W+1-SAMPLE_W){s1_sample_reg[SAMPLE_W-1]}}, s1_sample_reg};
        sat  = (wide[SUM_W] != wide[SUM_W-1]);
        if (sat)
            sum = wide[SUM_W] ? SUM_MIN : SUM_MAX;
        else
            sum = wide[SUM_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (free)
                s1_valid_reg <= accept;
            if (s1_go)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && free)
        begin
            s1_sample_reg <= sample;
            s1_plane_reg  <= plane;
            s1_addr_reg   <= addr;
            s1_flags_reg  <= flags;
        end
        if (s1_go)
        begin
            out_sum_reg  <= sum;
            out_sat_reg  <= sat;
            out_last_reg <= s1_flags_reg.last_item;
            if (!dir)
                plane_sums_reg[s1_plane_reg] <= sum;
        end
    end

    assign col_we    = s1_go && dir;
    assign col_addr  = s1_addr_reg;
    assign col_wdata = sum;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_sum_reg;
    assign m_tuser  = out_sat_reg;
    assign m_tlast  = out_last_reg;

    a_sat_clips: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> (m_tdata == SUM_MAX) || (m_tdata == SUM_MIN))
        else $error("saturated item without a clipped sum");

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_valid_reg && !m_tready |=> s1_valid_reg && $stable(s1_addr_reg))
        else $error("add stage lost an item while output stalled");

    a_store_only_column: assert property (@(posedge clk) disable iff (!rst_n)
        col_we |-> s1_valid_reg && out_valid_reg == 1'b0 || m_tready)
        else $error("column store written without the item advancing");

endmodule

@@ design/matrix_cumulative_sum.sv @@
// ----------------------------------------------------------------------------
// matrix_cumulative_sum
// Running sum of a raster-order matrix along rows or down columns, saturated.
// ----------------------------------------------------------------------------
//  channel   signals                         direction  content
//  s_*       s_tvalid s_tready s_tdata[31:0] in         sample (Q16.16)
//  m_*       m_tvalid m_tready m_tdata[47:0] out        running_sum (Q32.16)
//            m_tuser[0], m_tlast                        saturated, matrix_end
//  cfg_*     cfg_we cfg_index[1:0] cfg_data  in         register writes
//
//  One item per cycle while the output does not stall; each item passes the add stage,
//  which adds the registered column store read, and then the output register.
//  No clearing pass after reset: row zero writes every store entry it reads.
//  Any register write restarts the matrix at row, cell and plane zero.
//  A stalled output holds the add stage; s_tready drops only when the output
//  register and the add stage both hold items and m_tready is low.
// ----------------------------------------------------------------------------
module matrix_cumulative_sum #(
    parameter int MAX_ROW_LENGTH = mcs_pkg::DEF_MAX_ROW_LENGTH,
    parameter int MAX_PLANES     = mcs_pkg::DEF_MAX_PLANES
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic signed [mcs_pkg::SAMPLE_W-1:0]   s_tdata,   // [31:0] sample
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic signed [mcs_pkg::SUM_W-1:0]      m_tdata,   // [47:0] running_sum
    output logic                                  m_tuser,   // [0] saturated
    output logic                                  m_tlast,
    input  logic                                  cfg_we,
    input  mcs_pkg::cfg_reg_t                     cfg_index,
    input  logic [mcs_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import mcs_pkg::*;

    localparam int CW = $clog2(MAX_ROW_LENGTH);
    localparam int PW = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
    localparam int AW = $clog2(MAX_ROW_LENGTH * MAX_PLANES);

    logic                    dir;
    logic [CW-1:0]           last_cell;
    logic [PW-1:0]           last_plane;
    logic [ROWS_W-1:0]       last_row;
    logic                    accept;
    logic                    free;
    logic [PW-1:0]           plane;
    logic [AW-1:0]           addr;
    pos_flags_t              flags;
    logic signed [SUM_W-1:0] col_rdata;
    logic                    col_we;
    logic [AW-1:0]           col_addr;
    logic signed [SUM_W-1:0] col_wdata;

    assign s_tready = free;
    assign accept   = s_tvalid && free;

    mcs_config #(
        .MAX_ROW_LENGTH (MAX_ROW_LENGTH),
        .MAX_PLANES     (MAX_PLANES)
    ) u_config (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .dir        (dir),
        .last_cell  (last_cell),
        .last_plane (last_plane),
        .last_row   (last_row)
    );

    mcs_position #(
        .MAX_ROW_LENGTH (MAX_ROW_LENGTH),
        .MAX_PLANES     (MAX_PLANES)
    ) u_position (
        .clk        (clk),
        .rst_n      (rst_n),
        .restart    (cfg_we),
        .accept     (accept),
        .last_cell  (last_cell),
        .last_plane (last_plane),
        .last_row   (last_row),
        .plane      (plane),
        .addr       (addr),
        .flags      (flags)
    );

    mcs_column_store #(
        .MAX_ROW_LENGTH (MAX_ROW_LENGTH),
        .MAX_PLANES     (MAX_PLANES)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept && dir),
        .rd_addr (addr),
        .rd_data (col_rdata),
        .wr_en   (col_we),
        .wr_addr (col_addr),
        .wr_data (col_wdata)
    );

    mcs_accum #(
        .MAX_ROW_LENGTH (MAX_ROW_LENGTH),
        .MAX_PLANES     (MAX_PLANES)
    ) u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .dir       (dir),
        .accept    (accept),
        .sample    (s_tdata),
        .plane     (plane),
        .addr      (addr),
        .flags     (flags),
        .free      (free),
        .col_data  (col_rdata),
        .col_we    (col_we),
        .col_addr  (col_addr),
        .col_wdata (col_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

@@ tb/sv/tb_matrix_cumulative_sum.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_matrix_cumulative_sum
// Self-checking bench for the row/column running sum of a raster matrix.
// Samples stream in with random gaps and output stalls. A behavioral
// predictor tracks the register settings, the positions and both sum stores,
// and queues one expected sum per accepted sample. The checker compares every
// result field against the oldest entry of that queue.
// ----------------------------------------------------------------------------
module tb_matrix_cumulative_sum;
    import mcs_pkg::*;

    localparam int          STORE_SLOTS   = DEF_MAX_ROW_LENGTH * DEF_MAX_PLANES;
    localparam int          RANDOM_ITEMS  = 800;
    localparam int          CALM_ITEMS    = 300;
    localparam int          MAX_PRINTED   = 40;
    localparam longint      LIMIT_NS      = 64'd12_000_000;

    typedef struct packed {
        logic [SUM_W-1:0] running_sum;
        logic             saturated;
        logic             matrix_end;
    } sum_result_t;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        s_tvalid;
    logic                        s_tready;
    logic signed [SAMPLE_W-1:0]  s_tdata;     // [31:0] sample
    logic                        m_tvalid;
    logic                        m_tready;
    logic signed [SUM_W-1:0]     m_tdata;     // [47:0] running_sum
    logic                        m_tuser;     // [0] saturated
    logic                        m_tlast;
    logic                        cfg_we;
    cfg_reg_t                    cfg_index;
    logic [CFG_DATA_W-1:0]       cfg_data;

    // Predictor copy of the registers and state
    logic                        cfg_dir;
    logic [LEN_W-1:0]            cfg_len;
    logic [ROWS_W-1:0]           cfg_rows;
    logic [PLANES_W-1:0]         cfg_planes;
    logic [SUM_W-1:0]            row_acc [DEF_MAX_PLANES];
    logic [SUM_W-1:0]            col_acc [STORE_SLOTS];
    int unsigned                 plane_at;
    int unsigned                 cell_at;
    int unsigned                 row_at;

    sum_result_t                 pending_sums[$];
    int unsigned                 samples_sent;
    int unsigned                 sums_checked;
    int unsigned                 reg_writes;
    int unsigned                 fail_count;
    int unsigned                 hold_off;
    bit                          src_idle_on;
    bit                          sink_idle_on;

    matrix_cumulative_sum dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int unsigned cells_per_row();
        if (cfg_len == 0)
            return 1;
        if (cfg_len > DEF_MAX_ROW_LENGTH)
            return DEF_MAX_ROW_LENGTH;
        return 32'(cfg_len);
    endfunction

    function automatic int unsigned planes_per_cell();
        if (cfg_planes == 0)
            return 1;
        if (cfg_planes > DEF_MAX_PLANES)
            return DEF_MAX_PLANES;
        return 32'(cfg_planes);
    endfunction

    function automatic int unsigned rows_per_matrix();
        return (cfg_rows == 0) ? 1 : 32'(cfg_rows);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return 32'sh0000_0000;
            3:       return 32'shFFFF_FFFF;
            4:       return $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
            default: return $urandom();
        endcase
    endfunction

    task automatic restart_positions();
        foreach (row_acc[p])
            row_acc[p] = '0;
        plane_at = 0;
        cell_at  = 0;
        row_at   = 0;
    endtask

    // Work out the sum for one accepted sample and advance the raster position
    task automatic predict_sum(input logic signed [SAMPLE_W-1:0] sample);
        int unsigned planes;
        int unsigned len;
        int unsigned rows;
        int unsigned slot;
        longint      acc;
        sum_result_t res;
        planes = planes_per_cell();
        len    = cells_per_row();
        rows   = rows_per_matrix();
        slot   = cell_at * DEF_MAX_PLANES + plane_at;
        acc    = longint'(sample);
        if (!cfg_dir)
        begin
            if (cell_at != 0)
                acc += longint'($signed(row_acc[plane_at]));
        end
        else if (row_at != 0)
        begin
            acc += longint'($signed(col_acc[slot]));
        end
        res.saturated = 1'b0;
        if (acc > longint'(SUM_MAX))
        begin
            acc = longint'(SUM_MAX);
            res.saturated = 1'b1;
        end
        if (acc < longint'(SUM_MIN))
        begin
            acc = longint'(SUM_MIN);
            res.saturated = 1'b1;
        end
        if (!cfg_dir)
            row_acc[plane_at] = acc[SUM_W-1:0];
        else
            col_acc[slot] = acc[SUM_W-1:0];
        res.running_sum = acc[SUM_W-1:0];
        res.matrix_end  = (plane_at + 1 >= planes) && (cell_at + 1 >= len) &&
                          (row_at + 1 >= rows);
        pending_sums.push_back(res);

        if (plane_at + 1 < planes)
            plane_at++;
        else
        begin
            plane_at = 0;
            if (cell_at + 1 < len)
                cell_at++;
            else
            begin
                cell_at = 0;
                row_at  = (row_at + 1 >= rows) ? 0 : row_at + 1;
            end
        end
    endtask

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
        int gap;
        @(negedge clk);
        if (src_idle_on && $urandom_range(0, 5) == 0)
        begin
            s_tvalid = 1'b0;
            gap = $urandom_range(1, 12);
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = value;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_sum(value);
        samples_sent++;
    endtask

    // Drop the source and let every outstanding sum drain out
    task automatic wait_idle();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending_sums.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t index, input logic [CFG_DATA_W-1:0] value);
        wait_idle();
        cfg_we    = 1'b1;
        cfg_index = index;
        cfg_data  = value;
        @(negedge clk);
        cfg_we = 1'b0;
        case (index)
            REG_SUM_DIRECTION: cfg_dir    = value[0];
            REG_ROW_LENGTH:    cfg_len    = value[LEN_W-1:0];
            REG_ROW_COUNT:     cfg_rows   = value[ROWS_W-1:0];
            REG_PLANE_COUNT:   cfg_planes = value[PLANES_W-1:0];
            default:           cfg_dir    = cfg_dir;
        endcase
        restart_positions();
        reg_writes++;
    endtask

    task automatic set_shape(input logic dir, input logic [CFG_DATA_W-1:0] len,
                             input logic [CFG_DATA_W-1:0] rows,
                             input logic [CFG_DATA_W-1:0] planes);
        write_reg(REG_SUM_DIRECTION, {15'd0, dir});
        write_reg(REG_ROW_LENGTH, len);
        write_reg(REG_ROW_COUNT, rows);
        write_reg(REG_PLANE_COUNT, planes);
    endtask

    task automatic report_mismatch(input string field, input logic [SUM_W-1:0] got,
                                   input logic [SUM_W-1:0] want);
        fail_count++;
        // keep the log short on a badly broken design
        if (fail_count <= MAX_PRINTED)
            $display("tb: %s mismatch at %0t ns after %0d sums: got %h, want %h",
                     field, $time, sums_checked, got, want);
    endtask

    always @(posedge clk)
    begin
        sum_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_sums.size() == 0)
                report_mismatch("unexpected result", m_tdata, '0);
            else
            begin
                want = pending_sums.pop_front();
                if (m_tdata !== want.running_sum)
                    report_mismatch("running_sum", m_tdata, want.running_sum);
                if (m_tuser !== want.saturated)
                    report_mismatch("saturated", SUM_W'(m_tuser), SUM_W'(want.saturated));
                if (m_tlast !== want.matrix_end)
                    report_mismatch("matrix_end", SUM_W'(m_tlast), SUM_W'(want.matrix_end));
            end
            sums_checked++;
        end
    end

    // Output side: long hold-off on request, otherwise random stall bursts
    initial
    begin
        int stall;
        stall    = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off > 0)
            begin
                m_tready = 1'b0;
                hold_off--;
            end
            else if (stall > 0)
            begin
                m_tready = 1'b0;
                stall--;
            end
            else if (sink_idle_on && $urandom_range(0, 5) == 0)
            begin
                m_tready = 1'b0;
                stall = $urandom_range(1, 12) - 1;
            end
            else
                m_tready = 1'b1;
        end
    end

    task automatic test_reset_shape();
        // after reset the block is a 1x1x1 row-mode matrix
        send_sample(32'sh7FFF_FFFF);
        send_sample(32'sh8000_0000);
        send_sample(32'sh0001_0000);
    endtask

    task automatic test_row_sums();
        logic signed [SAMPLE_W-1:0] vals [8] = '{
            32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
            32'sh8000_0000, 32'shFFFF_FFFF, 32'sh0000_0001, 32'sh7FFF_FFFF};
        set_shape(1'b0, 16'd2, 16'd2, 16'd2);
        foreach (vals[i])
            send_sample(vals[i]);
    endtask

    task automatic test_column_sums();
        logic signed [SAMPLE_W-1:0] vals [7] = '{
            32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
            32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0005};
        // the last sample wraps into a fresh matrix
        set_shape(1'b1, 16'd2, 16'd3, 16'd1);
        foreach (vals[i])
            send_sample(vals[i]);
    endtask

    task automatic test_zero_sizes();
        set_shape(1'b1, 16'd0, 16'd0, 16'd0);
        repeat (3) send_sample(pick_sample());
        write_reg(REG_SUM_DIRECTION, 16'd0);
        repeat (2) send_sample(pick_sample());
    endtask

    task automatic test_restart_mid_matrix();
        set_shape(1'b1, 16'd2, 16'd2, 16'd1);
        repeat (3) send_sample(pick_sample());
        write_reg(REG_ROW_COUNT, 16'd2);
        repeat (4) send_sample(pick_sample());
    endtask

    task automatic test_widest_shape();
        // upper bits are masked off: length folds to the line size, planes to one
        set_shape(1'b1, 16'hFFFF, 16'd2, 16'hFFF9);
        repeat (DEF_MAX_ROW_LENGTH + 16) send_sample(pick_sample());
    endtask

    task automatic test_tallest_column();
        int unsigned n;
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        set_shape(1'b1, 16'd1, 16'hFFFF, 16'd1);
        for (n = 0; n < 63; n++)
            send_sample(32'sh8000_0000);
        send_sample(32'sh7FFF_FFFF);
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
    endtask

    task automatic test_output_backpressure();
        src_idle_on = 1'b0;
        set_shape(1'b1, 16'd5, 16'd4, 16'd2);
        hold_off = 300;
        repeat (40) send_sample(pick_sample());
        src_idle_on = 1'b1;
    endtask

    task automatic test_random_matrices();
        int unsigned       sent;
        int unsigned       total;
        int unsigned       shape_items;
        logic [15:0]       noise;
        logic [LEN_W-1:0]  len;
        logic [ROWS_W-1:0] rows;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            noise = 16'($urandom());
            case ($urandom_range(0, 9))
                0:       len = '0;
                1:       len = LEN_W'($urandom_range(9, 64));
                default: len = LEN_W'($urandom_range(1, 8));
            endcase
            rows = ($urandom_range(0, 7) == 0) ? '0 : ROWS_W'($urandom_range(1, 6));
            write_reg(REG_SUM_DIRECTION, {noise[15:1], 1'($urandom_range(0, 1))});
            write_reg(REG_ROW_LENGTH, {noise[4:0], len});
            write_reg(REG_ROW_COUNT, rows);
            write_reg(REG_PLANE_COUNT, {noise[12:0], 3'($urandom_range(0, 7))});

            if (sent + CALM_ITEMS >= RANDOM_ITEMS)
            begin
                src_idle_on  = 1'b0;
                sink_idle_on = 1'b0;
            end
            else
            begin
                src_idle_on  = ($urandom_range(0, 3) != 0);
                sink_idle_on = ($urandom_range(0, 3) != 0);
            end

            shape_items = cells_per_row() * rows_per_matrix() * planes_per_cell();
            // mostly whole matrices; now and then cut one short
            if ($urandom_range(0, 4) == 0)
                total = $urandom_range(1, shape_items);
            else if (shape_items > 200)
                total = shape_items;
            else
                total = shape_items * $urandom_range(1, 3);
            if (total > RANDOM_ITEMS - sent)
                total = RANDOM_ITEMS - sent;
            repeat (total) send_sample(pick_sample());
            sent += total;
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        cfg_we       = 1'b0;
        cfg_index    = REG_SUM_DIRECTION;
        cfg_data     = '0;
        cfg_dir      = 1'b0;
        cfg_len      = 1;
        cfg_rows     = 1;
        cfg_planes   = 1;
        samples_sent = 0;
        sums_checked = 0;
        reg_writes   = 0;
        fail_count   = 0;
        hold_off     = 0;
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        foreach (col_acc[i])
            col_acc[i] = '0;
        restart_positions();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_shape();
        test_row_sums();
        test_column_sums();
        test_zero_sizes();
        test_restart_mid_matrix();
        test_widest_shape();
        test_tallest_column();
        test_output_backpressure();
        test_random_matrices();

        wait_idle();
        repeat (8) @(posedge clk);
        $display("tb: %0d samples, %0d sums checked, %0d register writes",
                 samples_sent, sums_checked, reg_writes);
        $display("tb: row and column sums, size corners, restarts and output stalls covered");
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #(LIMIT_NS);
        $display("tb: failure");
        $finish;
    end

endmodule
